// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each module that asserts has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define BRLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define BRLS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/brls_pkg.sv -----
`timescale 1ns / 1ps

package brls_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam logic [5:0] SH_F  = 6'(FRAC_BITS);
  localparam logic [5:0] SH_F1 = 6'(FRAC_BITS + 1);
  localparam logic [5:0] SH_2F = 6'(2 * FRAC_BITS);

  localparam longint unsigned GRAV_FULL = (981 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [23:0] GRAV_RESET = 24'(GRAV_FULL);

  localparam logic [63:0] ONE2  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] TWO_F = 64'd2 << FRAC_BITS;
  localparam logic [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] INT64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [63:0] INT32_MAX = {33'd0, {31{1'b1}}};
  localparam logic [63:0] INT32_MIN = {{33{1'b1}}, 31'd0};

  typedef enum logic [2:0] {
    K_ADD, K_SUB, K_MAX, K_CLIP, K_MOV, K_TESTZ, K_MUL, K_DIV
  } alu_kind_e;

  typedef struct packed {
    alu_kind_e   kind;
    logic [5:0]  sh;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    alu_kind_e  kind;
    logic [4:0] dst;
    logic [5:0] opa;
    logic [5:0] opb;
    logic [5:0] sh;
    logic       last;
  } op_t;

  // Register file addresses (bit 5 clear) and fixed operands (bit 5 set).
  localparam logic [5:0] R_FST = 6'd0;
  localparam logic [5:0] R_FSX = 6'd1;
  localparam logic [5:0] R_FSY = 6'd2;
  localparam logic [5:0] R_FSZ = 6'd3;
  localparam logic [5:0] R_P00 = 6'd4;
  localparam logic [5:0] R_P01 = 6'd5;
  localparam logic [5:0] R_P11 = 6'd6;
  localparam logic [5:0] R_VX  = 6'd7;
  localparam logic [5:0] R_VY  = 6'd8;
  localparam logic [5:0] R_VZ  = 6'd9;
  localparam logic [5:0] R_CX  = 6'd10;
  localparam logic [5:0] R_CY  = 6'd11;
  localparam logic [5:0] R_CZ  = 6'd12;
  localparam logic [5:0] R_DT  = 6'd16;
  localparam logic [5:0] R_ZC  = 6'd17;
  localparam logic [5:0] R_T0  = 6'd18;
  localparam logic [5:0] R_T1  = 6'd19;
  localparam logic [5:0] R_T2  = 6'd20;
  localparam logic [5:0] R_T3  = 6'd21;
  localparam logic [5:0] R_T4  = 6'd22;
  localparam logic [5:0] O_T    = 6'd32;
  localparam logic [5:0] O_X    = 6'd33;
  localparam logic [5:0] O_Y    = 6'd34;
  localparam logic [5:0] O_Z    = 6'd35;
  localparam logic [5:0] O_GRAV = 6'd36;
  localparam logic [5:0] O_ONE2 = 6'd37;
  localparam logic [5:0] O_TWO  = 6'd38;
  localparam logic [5:0] O_ZERO = 6'd39;

  localparam int unsigned PC_W = 7;
  localparam logic [PC_W-1:0] PC_STORE = 7'd0;
  localparam logic [PC_W-1:0] PC_PAIR  = 7'd4;
  localparam logic [PC_W-1:0] PC_UPD   = 7'd41;
  localparam logic [PC_W-1:0] PROG_LEN = 7'd92;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic hi_nz,
                                           input logic [63:0] lo);
    if (hi_nz || lo[63]) begin
      from_mag = neg ? INT64_MIN : INT64_MAX;
    end else begin
      from_mag = neg ? (64'd0 - lo) : lo;
    end
  endfunction

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd = s[64] ? INT64_MIN : INT64_MAX;
    end else begin
      sadd = s[63:0];
    end
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      ssub = s[64] ? INT64_MIN : INT64_MAX;
    end else begin
      ssub = s[63:0];
    end
  endfunction

  function automatic op_t mk(input alu_kind_e kind, input logic [5:0] dst,
                             input logic [5:0] opa, input logic [5:0] opb,
                             input logic [5:0] sh, input logic last);
    mk.kind = kind;
    mk.dst  = dst[4:0];
    mk.opa  = opa;
    mk.opb  = opb;
    mk.sh   = sh;
    mk.last = last;
  endfunction

  // Microcode: sample store, two-point fit and recursive update.
  function automatic op_t prog_rom(input logic [PC_W-1:0] pc);
    unique case (pc)
      // Store the first sample.
      7'd0:  prog_rom = mk(K_MOV, R_FST, O_T, O_ZERO, 6'd0, 1'b0);
      7'd1:  prog_rom = mk(K_MOV, R_FSX, O_X, O_ZERO, 6'd0, 1'b0);
      7'd2:  prog_rom = mk(K_MOV, R_FSY, O_Y, O_ZERO, 6'd0, 1'b0);
      7'd3:  prog_rom = mk(K_MOV, R_FSZ, O_Z, O_ZERO, 6'd0, 1'b1);
      // Two-point fit.
      7'd4:  prog_rom = mk(K_SUB, R_DT, O_T, R_FST, 6'd0, 1'b0);
      7'd5:  prog_rom = mk(K_TESTZ, R_DT, R_DT, O_ZERO, 6'd0, 1'b0);
      7'd6:  prog_rom = mk(K_MUL, R_ZC, O_T, O_T, SH_F, 1'b0);
      7'd7:  prog_rom = mk(K_MUL, R_ZC, O_GRAV, R_ZC, SH_F1, 1'b0);
      7'd8:  prog_rom = mk(K_ADD, R_ZC, O_Z, R_ZC, 6'd0, 1'b0);
      7'd9:  prog_rom = mk(K_ADD, R_T0, R_FST, O_T, 6'd0, 1'b0);
      7'd10: prog_rom = mk(K_MUL, R_T1, R_FST, R_FST, SH_F, 1'b0);
      7'd11: prog_rom = mk(K_MUL, R_T2, O_T, O_T, SH_F, 1'b0);
      7'd12: prog_rom = mk(K_ADD, R_T1, R_T1, R_T2, 6'd0, 1'b0);
      7'd13: prog_rom = mk(K_DIV, R_T2, O_TWO, R_DT, SH_F, 1'b0);
      7'd14: prog_rom = mk(K_DIV, R_P00, R_T2, R_DT, SH_2F, 1'b0);
      7'd15: prog_rom = mk(K_DIV, R_T2, R_T0, R_DT, SH_F, 1'b0);
      7'd16: prog_rom = mk(K_DIV, R_T2, R_T2, R_DT, SH_2F, 1'b0);
      7'd17: prog_rom = mk(K_SUB, R_P01, O_ZERO, R_T2, 6'd0, 1'b0);
      7'd18: prog_rom = mk(K_DIV, R_T2, R_T1, R_DT, SH_F, 1'b0);
      7'd19: prog_rom = mk(K_DIV, R_P11, R_T2, R_DT, SH_2F, 1'b0);
      7'd20: prog_rom = mk(K_SUB, R_T2, O_X, R_FSX, 6'd0, 1'b0);
      7'd21: prog_rom = mk(K_DIV, R_T2, R_T2, R_DT, SH_F, 1'b0);
      7'd22: prog_rom = mk(K_MUL, R_T3, R_T2, R_FST, SH_F, 1'b0);
      7'd23: prog_rom = mk(K_SUB, R_T3, R_FSX, R_T3, 6'd0, 1'b0);
      7'd24: prog_rom = mk(K_CLIP, R_VX, R_T2, O_ZERO, 6'd0, 1'b0);
      7'd25: prog_rom = mk(K_CLIP, R_CX, R_T3, O_ZERO, 6'd0, 1'b0);
      7'd26: prog_rom = mk(K_SUB, R_T2, O_Y, R_FSY, 6'd0, 1'b0);
      7'd27: prog_rom = mk(K_DIV, R_T2, R_T2, R_DT, SH_F, 1'b0);
      7'd28: prog_rom = mk(K_MUL, R_T3, R_T2, R_FST, SH_F, 1'b0);
      7'd29: prog_rom = mk(K_SUB, R_T3, R_FSY, R_T3, 6'd0, 1'b0);
      7'd30: prog_rom = mk(K_CLIP, R_VY, R_T2, O_ZERO, 6'd0, 1'b0);
      7'd31: prog_rom = mk(K_CLIP, R_CY, R_T3, O_ZERO, 6'd0, 1'b0);
      7'd32: prog_rom = mk(K_MUL, R_T4, R_FST, R_FST, SH_F, 1'b0);
      7'd33: prog_rom = mk(K_MUL, R_T4, O_GRAV, R_T4, SH_F1, 1'b0);
      7'd34: prog_rom = mk(K_ADD, R_T4, R_FSZ, R_T4, 6'd0, 1'b0);
      7'd35: prog_rom = mk(K_SUB, R_T2, R_ZC, R_T4, 6'd0, 1'b0);
      7'd36: prog_rom = mk(K_DIV, R_T2, R_T2, R_DT, SH_F, 1'b0);
      7'd37: prog_rom = mk(K_MUL, R_T3, R_T2, R_FST, SH_F, 1'b0);
      7'd38: prog_rom = mk(K_SUB, R_T3, R_T4, R_T3, 6'd0, 1'b0);
      7'd39: prog_rom = mk(K_CLIP, R_VZ, R_T2, O_ZERO, 6'd0, 1'b0);
      7'd40: prog_rom = mk(K_CLIP, R_CZ, R_T3, O_ZERO, 6'd0, 1'b1);
      // Recursive update.
      7'd41: prog_rom = mk(K_MUL, R_ZC, O_T, O_T, SH_F, 1'b0);
      7'd42: prog_rom = mk(K_MUL, R_ZC, O_GRAV, R_ZC, SH_F1, 1'b0);
      7'd43: prog_rom = mk(K_ADD, R_ZC, O_Z, R_ZC, 6'd0, 1'b0);
      7'd44: prog_rom = mk(K_MUL, R_T0, R_P00, O_T, SH_F, 1'b0);
      7'd45: prog_rom = mk(K_ADD, R_T0, R_T0, R_P01, 6'd0, 1'b0);
      7'd46: prog_rom = mk(K_MUL, R_T1, R_P01, O_T, SH_F, 1'b0);
      7'd47: prog_rom = mk(K_ADD, R_T1, R_T1, R_P11, 6'd0, 1'b0);
      7'd48: prog_rom = mk(K_MUL, R_T2, O_T, R_T0, SH_F, 1'b0);
      7'd49: prog_rom = mk(K_ADD, R_T2, O_ONE2, R_T2, 6'd0, 1'b0);
      7'd50: prog_rom = mk(K_ADD, R_T2, R_T2, R_T1, 6'd0, 1'b0);
      7'd51: prog_rom = mk(K_MAX, R_T2, R_T2, O_ONE2, 6'd0, 1'b0);
      7'd52: prog_rom = mk(K_MUL, R_T3, R_T0, R_T0, SH_2F, 1'b0);
      7'd53: prog_rom = mk(K_DIV, R_T3, R_T3, R_T2, SH_2F, 1'b0);
      7'd54: prog_rom = mk(K_SUB, R_P00, R_P00, R_T3, 6'd0, 1'b0);
      7'd55: prog_rom = mk(K_MUL, R_T3, R_T0, R_T1, SH_2F, 1'b0);
      7'd56: prog_rom = mk(K_DIV, R_T3, R_T3, R_T2, SH_2F, 1'b0);
      7'd57: prog_rom = mk(K_SUB, R_P01, R_P01, R_T3, 6'd0, 1'b0);
      7'd58: prog_rom = mk(K_MUL, R_T3, R_T1, R_T1, SH_2F, 1'b0);
      7'd59: prog_rom = mk(K_DIV, R_T3, R_T3, R_T2, SH_2F, 1'b0);
      7'd60: prog_rom = mk(K_SUB, R_P11, R_P11, R_T3, 6'd0, 1'b0);
      7'd61: prog_rom = mk(K_MUL, R_T0, R_P00, O_T, SH_F, 1'b0);
      7'd62: prog_rom = mk(K_ADD, R_T0, R_T0, R_P01, 6'd0, 1'b0);
      7'd63: prog_rom = mk(K_MUL, R_T1, R_P01, O_T, SH_F, 1'b0);
      7'd64: prog_rom = mk(K_ADD, R_T1, R_T1, R_P11, 6'd0, 1'b0);
      7'd65: prog_rom = mk(K_MUL, R_T2, R_VX, O_T, SH_F, 1'b0);
      7'd66: prog_rom = mk(K_ADD, R_T2, R_T2, R_CX, 6'd0, 1'b0);
      7'd67: prog_rom = mk(K_SUB, R_T2, O_X, R_T2, 6'd0, 1'b0);
      7'd68: prog_rom = mk(K_MUL, R_T3, R_T0, R_T2, SH_2F, 1'b0);
      7'd69: prog_rom = mk(K_ADD, R_T3, R_VX, R_T3, 6'd0, 1'b0);
      7'd70: prog_rom = mk(K_MUL, R_T4, R_T1, R_T2, SH_2F, 1'b0);
      7'd71: prog_rom = mk(K_ADD, R_T4, R_CX, R_T4, 6'd0, 1'b0);
      7'd72: prog_rom = mk(K_CLIP, R_VX, R_T3, O_ZERO, 6'd0, 1'b0);
      7'd73: prog_rom = mk(K_CLIP, R_CX, R_T4, O_ZERO, 6'd0, 1'b0);
      7'd74: prog_rom = mk(K_MUL, R_T2, R_VY, O_T, SH_F, 1'b0);
      7'd75: prog_rom = mk(K_ADD, R_T2, R_T2, R_CY, 6'd0, 1'b0);
      7'd76: prog_rom = mk(K_SUB, R_T2, O_Y, R_T2, 6'd0, 1'b0);
      7'd77: prog_rom = mk(K_MUL, R_T3, R_T0, R_T2, SH_2F, 1'b0);
      7'd78: prog_rom = mk(K_ADD, R_T3, R_VY, R_T3, 6'd0, 1'b0);
      7'd79: prog_rom = mk(K_MUL, R_T4, R_T1, R_T2, SH_2F, 1'b0);
      7'd80: prog_rom = mk(K_ADD, R_T4, R_CY, R_T4, 6'd0, 1'b0);
      7'd81: prog_rom = mk(K_CLIP, R_VY, R_T3, O_ZERO, 6'd0, 1'b0);
      7'd82: prog_rom = mk(K_CLIP, R_CY, R_T4, O_ZERO, 6'd0, 1'b0);
      7'd83: prog_rom = mk(K_MUL, R_T2, R_VZ, O_T, SH_F, 1'b0);
      7'd84: prog_rom = mk(K_ADD, R_T2, R_T2, R_CZ, 6'd0, 1'b0);
      7'd85: prog_rom = mk(K_SUB, R_T2, R_ZC, R_T2, 6'd0, 1'b0);
      7'd86: prog_rom = mk(K_MUL, R_T3, R_T0, R_T2, SH_2F, 1'b0);
      7'd87: prog_rom = mk(K_ADD, R_T3, R_VZ, R_T3, 6'd0, 1'b0);
      7'd88: prog_rom = mk(K_MUL, R_T4, R_T1, R_T2, SH_2F, 1'b0);
      7'd89: prog_rom = mk(K_ADD, R_T4, R_CZ, R_T4, 6'd0, 1'b0);
      7'd90: prog_rom = mk(K_CLIP, R_VZ, R_T3, O_ZERO, 6'd0, 1'b0);
      7'd91: prog_rom = mk(K_CLIP, R_CZ, R_T4, O_ZERO, 6'd0, 1'b1);
      default: prog_rom = mk(K_MOV, R_T4, O_ZERO, O_ZERO, 6'd0, 1'b1);
    endcase
  endfunction

endpackage

// ----- rtl/ballistic_rls_trajectory_fit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tdata: sample_time, pos_x, pos_y, pos_z; tuser: restart
// m_axis    out        tdata: vel_x, vel_y, vel_z, icpt_x, icpt_y, icpt_z;
//                      tuser: singular, saturated
// cfg       in         data: gravity (write only, always ready)
//
// Each sample runs a short microcode program on one shared arithmetic unit, which
// sets the cost: a divide yields one quotient bit a cycle, a multiply sums four
// 32x32 partial products, and add, compare and clip are single steps.
// A stored first sample gives no result; a two-point fit (cut short when the times
// are equal) and a recursive update each end by loading the output register.
// s_axis_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next sample is accepted meanwhile.
// Reset (rst_ni low, asynchronous) empties the fit and restores the default gravity.

module ballistic_rls_trajectory_fit import brls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // sample_time, pos_x, pos_y, pos_z
  input  logic [0:0]   s_axis_tuser,  // restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // vel_x, vel_y, vel_z, icpt_x, icpt_y, icpt_z
  output logic [1:0]   m_axis_tuser,  // singular, saturated
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]      state_q;
  logic [PC_W-1:0] pc_q;
  logic [1:0]      count_q;
  logic            pair_q, store_q, sing_q, sat_q;
  logic [23:0]     grav_q;
  logic            m_valid_q;
  logic [191:0]    m_data_q;
  logic [1:0]      m_user_q;

  // Sample being processed.
  logic [31:0] t_q, x_q, y_q, z_q;

  // Working register file: first sample, covariance, parameters and temporaries.
  logic [63:0] rf_q [32];
  logic [63:0] rd_a_q, rd_b_q;
  logic [5:0]  opa_q, opb_q;

  // Parameter copies that feed the output register.
  logic [31:0] par_q [6];

  op_t         op;
  alu_req_t    req;
  logic        in_xfer, alu_done, alu_sat, wb_en;
  logic [63:0] alu_res;
  logic [63:0] opnd_a, opnd_b;

  assign op      = prog_rom(pc_q);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign wb_en   = (state_q == S_WAIT) && alu_done && (op.kind != K_TESTZ);

  function automatic logic [63:0] pick(input logic [5:0] code, input logic [63:0] rd);
    unique case (code)
      O_T:     pick = {32'd0, t_q};
      O_X:     pick = {{32{x_q[31]}}, x_q};
      O_Y:     pick = {{32{y_q[31]}}, y_q};
      O_Z:     pick = {{32{z_q[31]}}, z_q};
      O_GRAV:  pick = {40'd0, grav_q};
      O_ONE2:  pick = ONE2;
      O_TWO:   pick = TWO_F;
      O_ZERO:  pick = 64'd0;
      default: pick = code[5] ? 64'd0 : rd;
    endcase
  endfunction

  always_comb begin
    opnd_a   = pick(opa_q, rd_a_q);
    opnd_b   = pick(opb_q, rd_b_q);
    req.kind = op.kind;
    req.sh   = op.sh;
    req.a    = opnd_a;
    req.b    = opnd_b;
  end

  brls_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_ISSUE),
    .req_i   (req),
    .done_o  (alu_done),
    .res_o   (alu_res),
    .sat_o   (alu_sat)
  );

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= PC_STORE;
      count_q   <= 2'd0;
      pair_q    <= 1'b0;
      store_q   <= 1'b0;
      sing_q    <= 1'b0;
      sat_q     <= 1'b0;
      grav_q    <= GRAV_RESET;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        grav_q <= cfg_data_i;
      end
      // The output register loads at the finish step and empties on a result transfer.
      if ((state_q == S_FIN) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            sat_q   <= 1'b0;
            sing_q  <= 1'b0;
            state_q <= S_READ;
            if (s_axis_tuser[0] || (count_q == 2'd0)) begin
              pc_q    <= PC_STORE;
              count_q <= 2'd1;
              pair_q  <= 1'b0;
              store_q <= 1'b1;
            end else if (count_q == 2'd1) begin
              pc_q    <= PC_PAIR;
              pair_q  <= 1'b1;
              store_q <= 1'b0;
            end else begin
              pc_q    <= PC_UPD;
              pair_q  <= 1'b0;
              store_q <= 1'b0;
            end
          end
        end
        S_READ:  state_q <= S_ISSUE;
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (alu_done) begin
            if ((op.kind == K_CLIP) && alu_sat) begin
              sat_q <= 1'b1;
            end
            if ((op.kind == K_TESTZ) && (alu_res == 64'd0)) begin
              sing_q  <= 1'b1;
              state_q <= S_FIN;
            end else if (op.last) begin
              state_q <= store_q ? S_IDLE : S_FIN;
            end else begin
              pc_q    <= pc_q + 7'd1;
              state_q <= S_READ;
            end
          end
        end
        S_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
            if (pair_q && !sing_q) begin
              count_q <= 2'd2;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers and register file.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      t_q <= s_axis_tdata[31:0];
      x_q <= s_axis_tdata[63:32];
      y_q <= s_axis_tdata[95:64];
      z_q <= s_axis_tdata[127:96];
    end
    if (state_q == S_READ) begin
      rd_a_q <= rf_q[op.opa[4:0]];
      rd_b_q <= rf_q[op.opb[4:0]];
      opa_q  <= op.opa;
      opb_q  <= op.opb;
    end
    if (wb_en) begin
      rf_q[op.dst] <= alu_res;
    end
    if (wb_en && (op.kind == K_CLIP)) begin
      par_q[3'(op.dst - R_VX[4:0])] <= alu_res[31:0];
    end
    if ((state_q == S_FIN) && (!m_valid_q || m_axis_tready)) begin
      if (sing_q) begin
        m_data_q <= 192'd0;
        m_user_q <= 2'b01;
      end else begin
        m_data_q <= {par_q[5], par_q[4], par_q[3], par_q[2], par_q[1], par_q[0]};
        m_user_q <= {sat_q, 1'b0};
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign cfg_ready_o   = 1'b1;

`include "assert_macros.svh"

  `BRLS_NEVER(a_count_range, count_q == 2'd3, "sample count reached an unused value")
  `BRLS_ASSERT(a_pc_range, (state_q == S_READ) |-> (pc_q < PROG_LEN), "program counter ran off")
  `BRLS_ASSERT(a_done_in_wait, alu_done |-> (state_q == S_WAIT), "alu finished while not awaited")
  `BRLS_ASSERT(a_result_from_fin, $rose(m_axis_tvalid) |-> ($past(state_q) == S_FIN),
               "result raised outside the finish step")

endmodule

// ----- rtl/brls_alu.sv -----
`timescale 1ns / 1ps

module brls_alu import brls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  alu_req_t    req_i,
  output logic        done_o,
  output logic [63:0] res_o,
  output logic        sat_o
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_MRND = 3'd2;
  localparam logic [2:0] A_MFIN = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_DFIN = 3'd5;

  logic [2:0]   ast_q;
  logic [6:0]   cnt_q;
  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [5:0]   sh_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [63:0]  r_q, q_q;
  logic         ovf_q;
  logic [63:0]  res_q;
  logic         sat_q, done_q;

  logic [31:0]  mul_a, mul_b;
  logic [1:0]   prev_k;
  logic [127:0] pp_shift, rnd;
  logic [64:0]  r2;
  logic         ge;
  logic [63:0]  ma_in, mb_in;

  assign mul_a  = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign mul_b  = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign prev_k = cnt_q[1:0] - 2'd1;
  assign ma_in  = mag(req_i.a);
  assign mb_in  = mag(req_i.b);

  always_comb begin
    unique case (prev_k)
      2'd0:    pp_shift = {64'd0, pp_q};
      2'd3:    pp_shift = {pp_q, 64'd0};
      default: pp_shift = {32'd0, pp_q, 32'd0};
    endcase
    rnd = (sh_q == 6'd0) ? 128'd0 : (128'd1 << (sh_q - 6'd1));
    r2  = {r_q, acc_q[127]};
    ge  = r2 >= {1'b0, mb_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ast_q  <= A_IDLE;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      // Single-step kinds finish right after the start; multiply and divide at their end.
      done_q <= ((ast_q == A_IDLE) && start_i && (req_i.kind != K_MUL) &&
                 (req_i.kind != K_DIV)) || (ast_q == A_MFIN) || (ast_q == A_DFIN);
      unique case (ast_q)
        A_IDLE: begin
          if (start_i) begin
            if (req_i.kind == K_MUL) begin
              ast_q <= A_MUL;
              cnt_q <= 7'd0;
            end else if (req_i.kind == K_DIV) begin
              ast_q <= A_DIV;
              cnt_q <= 7'd127;
            end
          end
        end
        A_MUL: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd4) begin
            ast_q <= A_MRND;
          end
        end
        A_MRND: ast_q <= A_MFIN;
        A_MFIN: ast_q <= A_IDLE;
        A_DIV: begin
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) begin
            ast_q <= A_DFIN;
          end
        end
        A_DFIN: ast_q <= A_IDLE;
        default: ast_q <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ast_q)
      A_IDLE: begin
        if (start_i) begin
          sat_q <= (req_i.kind == K_CLIP) && (req_i.a[63:31] != {33{req_i.a[63]}});
          ma_q  <= ma_in;
          mb_q  <= mb_in;
          neg_q <= req_i.a[63] ^ req_i.b[63];
          sh_q  <= req_i.sh;
          r_q   <= 64'd0;
          q_q   <= 64'd0;
          ovf_q <= 1'b0;
          if (req_i.kind == K_DIV) begin
            acc_q <= ({64'd0, ma_in} << req_i.sh) + {65'd0, mb_in[63:1]};
          end else begin
            acc_q <= 128'd0;
          end
          unique case (req_i.kind)
            K_ADD: res_q <= sadd(req_i.a, req_i.b);
            K_SUB: res_q <= ssub(req_i.a, req_i.b);
            K_MAX: res_q <= ($signed(req_i.a) < $signed(req_i.b)) ? req_i.b : req_i.a;
            K_CLIP: begin
              if (req_i.a[63:31] == {33{req_i.a[63]}}) begin
                res_q <= req_i.a;
              end else begin
                res_q <= req_i.a[63] ? INT32_MIN : INT32_MAX;
              end
            end
            default: res_q <= req_i.a;
          endcase
        end
      end
      A_MUL: begin
        if (cnt_q != 7'd4) begin
          pp_q <= mul_a * mul_b;
        end
        if (cnt_q != 7'd0) begin
          acc_q <= acc_q + pp_shift;
        end
      end
      A_MRND: acc_q <= (acc_q + rnd) >> sh_q;
      A_MFIN: res_q <= from_mag(neg_q, |acc_q[127:64], acc_q[63:0]);
      A_DIV: begin
        acc_q <= {acc_q[126:0], 1'b0};
        r_q   <= ge ? 64'(r2 - {1'b0, mb_q}) : r2[63:0];
        ovf_q <= ovf_q | q_q[63];
        q_q   <= {q_q[62:0], ge};
      end
      A_DFIN: res_q <= from_mag(neg_q, ovf_q, q_q);
      default: res_q <= res_q;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

`include "assert_macros.svh"

  `BRLS_ASSERT(a_done_single, done_o |=> !done_o, "alu done held for two cycles")
  `BRLS_ASSERT(a_start_idle, start_i |-> (ast_q == A_IDLE), "alu started while busy")

endmodule
